// ----- rtl/core/phe_pkg.sv -----
package phe_pkg;

    localparam int BIN_W          = 8;
    localparam int NUM_BINS       = 1 << BIN_W;
    localparam int FUNC_W         = 2;
    localparam int OUT_W          = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [FUNC_W-1:0] FUNC_COUNT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    typedef logic [BIN_W-1:0] bin_t;

    // read result handed from the controller to the output stage
    typedef struct packed {
        logic             load;
        logic [OUT_W-1:0] count;
    } phe_rd_t;

endpackage

// ----- rtl/core/phe_ram.sv -----
module phe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/phe_ctrl.sv -----
module phe_ctrl #(
    parameter int COUNT_WIDTH = phe_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [phe_pkg::FUNC_W-1:0] func,
    input  phe_pkg::bin_t              sample_first,
    input  phe_pkg::bin_t              sample_second,
    input  phe_pkg::bin_t              sample_third,
    input  phe_pkg::bin_t              bin_select,
    input  logic                       out_free,
    output phe_pkg::phe_rd_t           rd,
    output logic                       ram_we,
    output phe_pkg::bin_t              ram_waddr,
    output logic [COUNT_WIDTH-1:0]     ram_wdata,
    output logic                       ram_re,
    output phe_pkg::bin_t              ram_raddr,
    input  logic [COUNT_WIDTH-1:0]     ram_rdata
);

    import phe_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CNT  = 2'd1;
    localparam logic [1:0] S_RQ   = 2'd2;
    localparam logic [1:0] S_RD   = 2'd3;

    logic [1:0]          state_reg, state_next;
    bin_t                addr_reg [3];
    logic [1:0]          inc_reg [3];
    logic [1:0]          pend_reg;
    logic [1:0]          idx_reg, idx_next;
    logic                rd_hit_reg;
    logic [NUM_BINS-1:0] valid_reg;

    logic                   accept;
    logic                   eq_ab, eq_ac, eq_bc;
    logic                   nxt_ok;
    logic [1:0]             nxt_idx;
    logic [COUNT_WIDTH-1:0] cur;
    logic [SUM_W-1:0]       sum;
    logic [OUT_W-1:0]       report;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    assign eq_ab = (sample_first == sample_second);
    assign eq_ac = (sample_first == sample_third);
    assign eq_bc = (sample_second == sample_third);

    // entries never written since reset or clear read as zero
    assign cur = rd_hit_reg ? ram_rdata : '0;
    assign sum = {1'b0, cur} + SUM_W'(inc_reg[idx_reg]);

    if (COUNT_WIDTH > OUT_W) begin : g_clamp
        assign report = (|cur[COUNT_WIDTH-1:OUT_W]) ? '1 : cur[OUT_W-1:0];
    end else begin : g_ext
        assign report = OUT_W'(cur);
    end

    // next distinct bin of the pixel still to be updated
    always_comb
    begin
        nxt_ok  = 1'b0;
        nxt_idx = idx_reg;
        if (idx_reg == 2'd0 && pend_reg[0])
        begin
            nxt_ok  = 1'b1;
            nxt_idx = 2'd1;
        end
        else if (idx_reg != 2'd2 && pend_reg[1])
        begin
            nxt_ok  = 1'b1;
            nxt_idx = 2'd2;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ram_re     = 1'b0;
        ram_raddr  = sample_first;
        ram_we     = 1'b0;
        ram_waddr  = addr_reg[idx_reg];
        ram_wdata  = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
        rd.load    = 1'b0;
        rd.count   = report;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_COUNT:
                        begin
                            ram_re     = 1'b1;
                            ram_raddr  = sample_first;
                            idx_next   = 2'd0;
                            state_next = S_CNT;
                        end
                        FUNC_READ:
                        begin
                            ram_raddr = bin_select;
                            if (out_free)
                            begin
                                ram_re     = 1'b1;
                                state_next = S_RD;
                            end
                            else
                            begin
                                state_next = S_RQ;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CNT:
            begin
                // write this bin and fetch the next one if any, always a different entry
                ram_we    = 1'b1;
                ram_raddr = addr_reg[nxt_idx];
                if (nxt_ok)
                begin
                    ram_re   = 1'b1;
                    idx_next = nxt_idx;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_RQ:
            begin
                ram_raddr = addr_reg[0];
                if (out_free)
                begin
                    ram_re     = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                rd.load    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= 2'd0;
            pend_reg   <= 2'b00;
            rd_hit_reg <= 1'b0;
            valid_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (ram_re)
            begin
                rd_hit_reg <= valid_reg[ram_raddr];
            end
            if (accept && func == FUNC_COUNT)
            begin
                pend_reg <= {!eq_ac && !eq_bc, !eq_ab};
            end
            if (accept && func == FUNC_CLEAR)
            begin
                valid_reg <= '0;
            end
            else if (ram_we)
            begin
                valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (func == FUNC_READ)
            begin
                addr_reg[0] <= bin_select;
            end
            else
            begin
                addr_reg[0] <= sample_first;
            end
            addr_reg[1] <= sample_second;
            addr_reg[2] <= sample_third;
            inc_reg[0]  <= 2'd1 + {1'b0, eq_ab} + {1'b0, eq_ac};
            inc_reg[1]  <= 2'd1 + {1'b0, eq_bc};
            inc_reg[2]  <= 2'd1;
        end
    end

endmodule

// ----- rtl/core/phe_out.sv -----
module phe_out (
    input  logic                      clk,
    input  logic                      rst_n,
    input  phe_pkg::phe_rd_t          rd,
    output logic                      out_free,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [phe_pkg::OUT_W-1:0] bin_count
);

    import phe_pkg::*;

    logic             valid_reg;
    logic [OUT_W-1:0] count_reg;

    // slot is free at the next edge if empty or being transferred now
    assign out_free  = !valid_reg || !out_stall;
    assign out_valid = valid_reg;
    assign bin_count = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rd.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.load)
        begin
            count_reg <= rd.count;
        end
    end

endmodule

// ----- rtl/core/pixel_histogram_engine_top.sv -----
// 256-bin pixel histogram. A count transfer (func 0) adds one to the bin of each of its three
// channel bytes, a read transfer (func 1) returns one bin's count on the output channel, a clear
// transfer (func 2) empties every bin and func 3 is ignored. Counters are COUNT_WIDTH bits and
// saturate; counts above 2^32-1 are reported as 2^32-1. The counters live in one RAM with a
// registered read and are updated by read, add, write back. A count first accepts and fetches
// the first bin, then takes a step per distinct bin among the three bytes, each writing one bin
// while fetching the next. A read waits for the output register to empty, fetches its bin and
// then loads the output register; clear and the unused code leave the controller idle. Per-bin
// valid flops make reset and clear immediate, so no clearing pass is needed. The output register
// holds a result while the next transfer is accepted.
module pixel_histogram_engine_top #(
    parameter int COUNT_WIDTH = phe_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [phe_pkg::FUNC_W-1:0] func,
    input  logic [phe_pkg::BIN_W-1:0]  sample_first,
    input  logic [phe_pkg::BIN_W-1:0]  sample_second,
    input  logic [phe_pkg::BIN_W-1:0]  sample_third,
    input  logic [phe_pkg::BIN_W-1:0]  bin_select,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [phe_pkg::OUT_W-1:0]  bin_count
);

    import phe_pkg::*;

    logic                   out_free;
    phe_rd_t                rd;
    logic                   ram_we;
    bin_t                   ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    bin_t                   ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;

    phe_ctrl #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .sample_first (sample_first),
        .sample_second(sample_second),
        .sample_third (sample_third),
        .bin_select   (bin_select),
        .out_free     (out_free),
        .rd           (rd),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata)
    );

    phe_ram #(
        .WIDTH(COUNT_WIDTH),
        .DEPTH(NUM_BINS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    phe_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rd),
        .out_free (out_free),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bin_count(bin_count)
    );

endmodule

// ----- rtl/core/phe_checker.sv -----
module phe_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic [phe_pkg::FUNC_W-1:0] func,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [phe_pkg::OUT_W-1:0]  bin_count
);

    import phe_pkg::*;

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // a held result keeps its value until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(bin_count))
        else $error("result changed while stalled");

    // a read into an empty output register shows its result after the RAM read and the load state
    a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && func == FUNC_READ && !out_valid |-> ##2 out_valid)
        else $error("read result missing");

    // only reads produce results
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && func != FUNC_READ && !out_valid |=> !out_valid)
        else $error("result without a read");

    // a count transfer holds off input while the update sequencer is busy with it
    a_count_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && func == FUNC_COUNT |=> in_stall)
        else $error("count transfer did not hold off input");

endmodule

bind pixel_histogram_engine_top phe_checker u_phe_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .func     (func),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .bin_count(bin_count)
);

// ----- bench/pixel_histogram_engine_top_tb.sv -----
module pixel_histogram_engine_top_tb #(
    parameter int COUNT_W = 32
);
    timeunit 1ns;
    timeprecision 1ps;

    import phe_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [63:0] COUNT_MAX =
        (COUNT_W >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << COUNT_W) - 64'd1);
    localparam logic [63:0] REPORT_MAX = 64'hFFFF_FFFF;
    localparam int STALL_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [FUNC_W-1:0] func = FUNC_COUNT;
    bin_t              sample_first = '0;
    bin_t              sample_second = '0;
    bin_t              sample_third = '0;
    bin_t              bin_select = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [OUT_W-1:0]  bin_count;

    logic [63:0]      hist_model [NUM_BINS];
    logic [OUT_W-1:0] expected_counts [$];
    logic [OUT_W-1:0] want_count;
    int               errors = 0;
    int               quiet_cycles = 0;
    bit               tx_idle_on = 1'b1;
    bit               rx_idle_on = 1'b0;
    int               hold_asked = 0;
    int               hold_taken = 0;
    int               hold_left = 0;

    pixel_histogram_engine_top #(
        .COUNT_WIDTH(COUNT_W)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .func(func),
        .sample_first(sample_first),
        .sample_second(sample_second),
        .sample_third(sample_third),
        .bin_select(bin_select),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bin_count(bin_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void bump_bin(input bin_t idx);
        if (hist_model[idx] < COUNT_MAX)
            hist_model[idx] = hist_model[idx] + 64'd1;
    endfunction

    task automatic update_histogram(input logic [FUNC_W-1:0] f, input bin_t a, input bin_t b,
                                    input bin_t c, input bin_t sel);
        case (f)
            FUNC_COUNT:
            begin
                bump_bin(a);
                bump_bin(b);
                bump_bin(c);
            end
            FUNC_READ:
                expected_counts.push_back((hist_model[sel] > REPORT_MAX) ?
                                          REPORT_MAX[OUT_W-1:0] : hist_model[sel][OUT_W-1:0]);
            FUNC_CLEAR:
                foreach (hist_model[i])
                    hist_model[i] = '0;
            default: ;
        endcase
    endtask

    // one transfer on the input channel, prediction applied once it is taken
    task automatic send_item(input logic [FUNC_W-1:0] f, input bin_t a, input bin_t b,
                             input bin_t c, input bin_t sel);
        if (tx_idle_on && $urandom_range(99) < 37)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 37)
                @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= f;
        sample_first  <= a;
        sample_second <= b;
        sample_third  <= c;
        bin_select    <= sel;
        do
            @(posedge clk);
        while (in_stall);
        update_histogram(f, a, b, c, sel);
    endtask

    // narrow picks keep hitting the same few bins so they collide and saturate
    function automatic bin_t pick_bin(input bit narrow);
        return narrow ? bin_t'($urandom_range(0, 7)) : bin_t'($urandom);
    endfunction

    task automatic send_random_item();
        int  r;
        bit  narrow;
        narrow = ($urandom_range(99) < 40);
        r = $urandom_range(99);
        if (r < 55)
            send_item(FUNC_COUNT, pick_bin(narrow), pick_bin(narrow), pick_bin(narrow),
                      bin_t'($urandom));
        else if (r < 92)
            send_item(FUNC_READ, bin_t'($urandom), bin_t'($urandom), bin_t'($urandom),
                      pick_bin(narrow));
        else if (r < 94)
            send_item(FUNC_CLEAR, bin_t'($urandom), bin_t'($urandom), bin_t'($urandom),
                      bin_t'($urandom));
        else
            send_item(FUNC_UNUSED, pick_bin(narrow), pick_bin(narrow), pick_bin(narrow),
                      pick_bin(narrow));
    endtask

    task automatic test_reset_state();
        send_item(FUNC_READ, 8'hFF, 8'hFF, 8'hFF, 8'd0);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd255);
    endtask

    task automatic test_directed();
        send_item(FUNC_COUNT, 8'd0, 8'd0, 8'd0, 8'd255);
        send_item(FUNC_COUNT, 8'd255, 8'd255, 8'd255, 8'd0);
        send_item(FUNC_COUNT, 8'd1, 8'd2, 8'd3, 8'd1);
        send_item(FUNC_COUNT, 8'd7, 8'd7, 8'd200, 8'd7);
        send_item(FUNC_COUNT, 8'hAA, 8'h55, 8'hAA, 8'h55);
        // unused code must leave the bins alone and produce nothing
        send_item(FUNC_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_READ, 8'd9, 8'd9, 8'd9, 8'd0);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd255);
        send_item(FUNC_READ, 8'd7, 8'd7, 8'd7, 8'd7);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd200);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'hAA);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'h55);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd1);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd4);
        send_item(FUNC_CLEAR, 8'd3, 8'd3, 8'd3, 8'd3);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd255);
        send_item(FUNC_COUNT, 8'd0, 8'd255, 8'd0, 8'd0);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd0);
        send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, 8'd255);
    endtask

    // each of the three increments saturates on its own
    task automatic test_saturation();
        bin_t s;
        s = 8'h5A;
        if (COUNT_W <= 10)
        begin
            while (hist_model[s] + 64'd3 < COUNT_MAX)
                send_item(FUNC_COUNT, s, s, s, bin_t'($urandom));
            send_item(FUNC_COUNT, s, s, s + 8'd1, 8'd0);
            send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, s);
            send_item(FUNC_COUNT, s, s, s, 8'd0);
            send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, s);
            send_item(FUNC_COUNT, s, s, s, 8'd0);
            send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, s);
            send_item(FUNC_READ, 8'd0, 8'd0, 8'd0, s + 8'd1);
        end
    endtask

    task automatic test_random_traffic(input int n);
        repeat (n)
            send_random_item();
    endtask

    task automatic test_back_to_back(input int n);
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        repeat (n)
            send_random_item();
        tx_idle_on = 1'b1;
        rx_idle_on <= 1'b1;
    endtask

    // receiver holds off while reads keep coming, so the block fills and stalls its input
    task automatic test_output_hold_off(input int n);
        hold_asked <= hold_asked + 1;
        tx_idle_on = 1'b0;
        repeat (n)
        begin
            if ($urandom_range(99) < 70)
                send_item(FUNC_READ, bin_t'($urandom), bin_t'($urandom), bin_t'($urandom),
                          pick_bin(1'($urandom_range(1))));
            else
                send_item(FUNC_COUNT, pick_bin(1'b1), pick_bin(1'b1), pick_bin(1'b0),
                          bin_t'($urandom));
        end
        tx_idle_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_taken != hold_asked)
        begin
            hold_taken <= hold_asked;
            hold_left  <= STALL_HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= rx_idle_on && ($urandom_range(99) < 37);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_counts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual bin_count=%0d",
                         $time, bin_count);
            end
            else
            begin
                want_count = expected_counts.pop_front();
                if (bin_count !== want_count)
                begin
                    errors++;
                    $display("%0t: bin_count mismatch: expected %0d, actual %0d",
                             $time, want_count, bin_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        foreach (hist_model[i])
            hist_model[i] = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        rx_idle_on <= 1'b1;
        test_saturation();
        test_random_traffic(280);
        test_back_to_back(140);
        test_output_hold_off(60);
        test_random_traffic(220);

        in_valid <= 1'b0;
        while (expected_counts.size() != 0)
            @(posedge clk);
        repeat (8)
            @(posedge clk);

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
